@@ src/lpbm_pkg.sv @@
// Shared types and constants of the LRU page buffer manager.
package lpbm_pkg;

   // Default number of frames and map entries.
   localparam int PAGES_DEFAULT = 256;

   // Fixed field widths.
   localparam int PAGE_W = 8;
   localparam int CFG_W = 9;
   localparam int CSR_IDX_W = 1;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PRELOAD_END = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFER_END = 1'b1;

   // Request beat.
   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [PAGE_W-1:0] code_page;
      logic code_page_valid;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [PAGE_W-1:0] frame;
      logic hit;
      logic load_needed;
      logic [PAGE_W-1:0] evicted_page;
      logic evicted_valid;
   } rsp_type;

   // How the front classified a request.
   typedef enum logic [1:0] {
      KIND_PAGED = 2'd0,
      KIND_PRELOAD = 2'd1,
      KIND_NONE = 2'd2
   } kind_type;

   // Queue entry between front and back.
   typedef struct packed {
      req_type req;
      kind_type kind;
   } item_type;

   // Configuration as seen by the back end.
   typedef struct packed {
      logic rebuild;
      logic [CFG_W-1:0] preload_end;
      logic [CFG_W-1:0] buffer_end;
   } cfg_type;

endpackage

@@ src/lru_page_buffer_manager.sv @@
// Top level of the LRU page buffer manager: front, queue and back end.
//
// Each request beat returns one result beat in order. A preloaded or repeated
// page passes the back-end states LOOK and DONE; a hit on the newest frame adds
// DECIDE. A miss adds DECIDE, MCHK, MEVICT and MFILL, and MTAG when the oldest
// frame holds the code page; a hit on an older frame adds DECIDE, HA, HB, HC.
// These steps come from the chain of dependent reads and writes on the ring
// memories, each of which has one read and one write port. The two-entry queue
// lets the front take beats while the back end works. After reset and after
// every configuration write the back end sweeps all PAGES memory entries, one
// per cycle, and takes no request until done; csr writes are always accepted.
module lru_page_buffer_manager #(
   parameter int PAGES = lpbm_pkg::PAGES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input lpbm_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output lpbm_pkg::rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [lpbm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lpbm_pkg::CFG_W-1:0] csr_wdata
);

   logic q_full, q_push, q_pop, q_valid;
   lpbm_pkg::item_type push_item, pop_item;
   lpbm_pkg::cfg_type cfg;
   logic sweeping;

   lpbm_front #(.PAGES(PAGES)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .q_full(q_full),
      .q_push(q_push),
      .q_item(push_item),
      .cfg(cfg)
   );

   lpbm_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(push_item),
      .full(q_full),
      .pop(q_pop),
      .pop_valid(q_valid),
      .pop_item(pop_item)
   );

   lpbm_back #(.PAGES(PAGES)) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .q_valid(q_valid),
      .q_item(pop_item),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .sweeping(sweeping)
   );

   // A result never reports both a hit and a load.
   a_hit_xor_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.load_needed))
      else $error("result reports hit and load together");

   // An eviction only happens on a load.
   a_evict_on_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted_valid) |-> rsp_data.load_needed)
      else $error("eviction without load");

   // A configuration write starts the rebuild sweep.
   a_cfg_sweep: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> ##2 sweeping)
      else $error("configuration write did not start the sweep");

   // No beat leaves the queue during the sweep.
   a_no_pop_sweep: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !q_pop)
      else $error("queue popped during sweep");

endmodule

@@ src/lpbm_fifo.sv @@
// Short queue that decouples request classification from the back end.
module lpbm_fifo (
   input logic clock,
   input logic reset,
   input logic push,
   input lpbm_pkg::item_type push_item,
   output logic full,
   input logic pop,
   output logic pop_valid,
   output lpbm_pkg::item_type pop_item
);

   localparam int DEPTH = lpbm_pkg::QUEUE_DEPTH;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   lpbm_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full = (count_ff == NW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/lpbm_front.sv @@
// Front end: configuration registers and request classification.
module lpbm_front #(
   parameter int PAGES = lpbm_pkg::PAGES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input lpbm_pkg::req_type req_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [lpbm_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lpbm_pkg::CFG_W-1:0] csr_wdata,
   input logic q_full,
   output logic q_push,
   output lpbm_pkg::item_type q_item,
   output lpbm_pkg::cfg_type cfg
);

   localparam int CW = ($clog2(PAGES + 1) > lpbm_pkg::CFG_W) ?
                       $clog2(PAGES + 1) : lpbm_pkg::CFG_W;

   logic [lpbm_pkg::CFG_W-1:0] preload_end_ff, preload_end_in;
   logic [lpbm_pkg::CFG_W-1:0] buffer_end_ff, buffer_end_in;
   logic rebuild_ff, rebuild_in;
   logic cfg_wr;
   logic [CW-1:0] pe_ext, be_ext, paged_end;

   assign csr_ready = 1'b1;
   assign cfg_wr = csr_valid && csr_ready;

   // Register writes; any write asks for a rebuild of the ring.
   always_comb begin
      preload_end_in = preload_end_ff;
      buffer_end_in = buffer_end_ff;
      rebuild_in = cfg_wr;
      if (cfg_wr) begin
         unique case (csr_index)
            lpbm_pkg::REG_PRELOAD_END: preload_end_in = csr_wdata;
            lpbm_pkg::REG_BUFFER_END: buffer_end_in = csr_wdata;
            default: rebuild_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preload_end_ff <= '0;
         buffer_end_ff <= lpbm_pkg::CFG_W'(256);
         rebuild_ff <= 1'b0;
      end else begin
         preload_end_ff <= preload_end_in;
         buffer_end_ff <= buffer_end_in;
         rebuild_ff <= rebuild_in;
      end
   end

   assign cfg.rebuild = rebuild_ff;
   assign cfg.preload_end = preload_end_ff;
   assign cfg.buffer_end = buffer_end_ff;

   // Classify the beat: preloaded, not servable, or paged.
   assign pe_ext = CW'(preload_end_ff);
   assign be_ext = CW'(buffer_end_ff);
   assign paged_end = (be_ext > CW'(PAGES)) ? CW'(PAGES) : be_ext;

   always_comb begin
      q_item.req = req_data;
      if (CW'(req_data.page) < pe_ext) begin
         q_item.kind = lpbm_pkg::KIND_PRELOAD;
      end else if ((CW'(req_data.page) >= CW'(PAGES)) || (pe_ext >= paged_end)) begin
         q_item.kind = lpbm_pkg::KIND_NONE;
      end else begin
         q_item.kind = lpbm_pkg::KIND_PAGED;
      end
   end

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

endmodule

@@ src/lpbm_back.sv @@
// Back end: ring and map memories, the LRU sequencer and the result register.
module lpbm_back #(
   parameter int PAGES = lpbm_pkg::PAGES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input lpbm_pkg::cfg_type cfg,
   input logic q_valid,
   input lpbm_pkg::item_type q_item,
   output logic q_pop,
   output logic rsp_valid,
   input logic rsp_stall,
   output lpbm_pkg::rsp_type rsp_data,
   output logic sweeping
);

   localparam int FW = $clog2(PAGES);
   localparam int PW = lpbm_pkg::PAGE_W;
   localparam int CW = ($clog2(PAGES + 1) > lpbm_pkg::CFG_W) ?
                       $clog2(PAGES + 1) : lpbm_pkg::CFG_W;

   typedef enum logic [11:0] {
      ST_SWEEP = 12'b000000000001,
      ST_IDLE = 12'b000000000010,
      ST_LOOK = 12'b000000000100,
      ST_DECIDE = 12'b000000001000,
      ST_MCHK = 12'b000000010000,
      ST_MTAG = 12'b000000100000,
      ST_MEVICT = 12'b000001000000,
      ST_MFILL = 12'b000010000000,
      ST_HA = 12'b000100000000,
      ST_HB = 12'b001000000000,
      ST_HC = 12'b010000000000,
      ST_DONE = 12'b100000000000
   } state_type;

   // Memories: ring links, frame tags (valid + page), page map (valid + frame).
   logic [FW-1:0] next_mem [PAGES];
   logic [FW-1:0] prev_mem [PAGES];
   logic [PW:0] tag_mem [PAGES];
   logic [FW:0] map_mem [PAGES];

   logic next_we, prev_we, tag_we, map_we;
   logic [FW-1:0] next_waddr, prev_waddr, tag_waddr, map_waddr;
   logic [FW-1:0] next_wdata, prev_wdata;
   logic [PW:0] tag_wdata;
   logic [FW:0] map_wdata;
   logic [FW-1:0] next_raddr, prev_raddr, tag_raddr, map_raddr;
   logic [FW-1:0] next_rd_ff, prev_rd_ff;
   logic [PW:0] tag_rd_ff;
   logic [FW:0] map_rd_ff;

   state_type st_ff, st_in;
   logic [FW-1:0] idx_ff, idx_in;
   lpbm_pkg::item_type item_ff, item_in;
   logic [FW-1:0] newest_ff, newest_in;
   logic [PW-1:0] last_page_ff, last_page_in;
   logic last_valid_ff, last_valid_in;
   logic [FW-1:0] last_frame_ff, last_frame_in;
   logic [FW-1:0] o_ff, o_in;
   logic [FW-1:0] f_ff, f_in;
   logic [FW-1:0] old_ff, old_in;
   logic [PW:0] ftag_ff, ftag_in;
   lpbm_pkg::rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   lpbm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Initial ring link values for the entry under the sweep counter.
   logic [CW-1:0] sw_i, sw_pe, sw_be, sw_inc, sw_dec, sw_next, sw_prev;
   logic sw_in_ring;
   logic [FW-1:0] newest_init;

   always_comb begin
      sw_i = CW'(idx_ff);
      sw_pe = CW'(cfg.preload_end);
      sw_be = (CW'(cfg.buffer_end) > CW'(PAGES)) ? CW'(PAGES) : CW'(cfg.buffer_end);
      sw_inc = sw_i + CW'(1);
      sw_dec = sw_i - CW'(1);
      sw_in_ring = (sw_i >= sw_pe) && (sw_i < sw_be);
      if (sw_in_ring) begin
         sw_next = (sw_inc == sw_be) ? sw_pe : sw_inc;
         sw_prev = (sw_i == sw_pe) ? (sw_be - CW'(1)) : sw_dec;
      end else begin
         sw_next = (sw_i == CW'(PAGES - 1)) ? '0 : sw_inc;
         sw_prev = (sw_i == '0) ? CW'(PAGES - 1) : sw_dec;
      end
      newest_init = (sw_pe < sw_be) ? FW'(sw_be - CW'(1)) : '0;
   end

   // Sequencer.
   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      item_in = item_ff;
      newest_in = newest_ff;
      last_page_in = last_page_ff;
      last_valid_in = last_valid_ff;
      last_frame_in = last_frame_ff;
      o_in = o_ff;
      f_in = f_ff;
      old_in = old_ff;
      ftag_in = ftag_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      q_pop = 1'b0;

      next_we = 1'b0;
      prev_we = 1'b0;
      tag_we = 1'b0;
      map_we = 1'b0;
      next_waddr = idx_ff;
      prev_waddr = idx_ff;
      tag_waddr = idx_ff;
      map_waddr = idx_ff;
      next_wdata = FW'(sw_next);
      prev_wdata = FW'(sw_prev);
      tag_wdata = '0;
      map_wdata = '0;

      map_raddr = FW'(item_ff.req.page);
      prev_raddr = newest_ff;
      next_raddr = map_rd_ff[FW-1:0];
      tag_raddr = prev_rd_ff;

      unique case (st_ff)
         ST_SWEEP: begin
            next_we = 1'b1;
            prev_we = 1'b1;
            tag_we = 1'b1;
            map_we = 1'b1;
            idx_in = idx_ff + FW'(1);
            if (idx_ff == FW'(PAGES - 1)) begin
               st_in = ST_IDLE;
               newest_in = newest_init;
               last_valid_in = 1'b0;
               last_frame_in = '0;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               item_in = q_item;
               st_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            res_in = '0;
            st_in = ST_DONE;
            unique case (item_ff.kind)
               lpbm_pkg::KIND_PRELOAD: begin
                  res_in.frame = item_ff.req.page;
                  res_in.hit = 1'b1;
                  last_page_in = item_ff.req.page;
                  last_valid_in = 1'b1;
                  last_frame_in = FW'(item_ff.req.page);
               end
               lpbm_pkg::KIND_PAGED: begin
                  if (last_valid_ff && (item_ff.req.page == last_page_ff)) begin
                     res_in.frame = PW'(last_frame_ff);
                     res_in.hit = 1'b1;
                  end else begin
                     st_in = ST_DECIDE;
                  end
               end
               default: ;
            endcase
         end
         ST_DECIDE: begin
            o_in = prev_rd_ff;
            if (!map_rd_ff[FW]) begin
               // Miss: look at the oldest frame and the one behind it.
               prev_raddr = prev_rd_ff;
               st_in = ST_MCHK;
            end else if (map_rd_ff[FW-1:0] == newest_ff) begin
               res_in.frame = PW'(map_rd_ff[FW-1:0]);
               res_in.hit = 1'b1;
               last_page_in = item_ff.req.page;
               last_valid_in = 1'b1;
               last_frame_in = map_rd_ff[FW-1:0];
               st_in = ST_DONE;
            end else begin
               // Hit on an older frame: fetch its neighbors.
               f_in = map_rd_ff[FW-1:0];
               prev_raddr = map_rd_ff[FW-1:0];
               st_in = ST_HA;
            end
         end
         ST_MCHK: begin
            // The oldest frame holds the code page: take the second oldest.
            if (item_ff.req.code_page_valid && tag_rd_ff[PW]
                && (tag_rd_ff[PW-1:0] == item_ff.req.code_page)) begin
               f_in = prev_rd_ff;
               st_in = ST_MTAG;
            end else begin
               f_in = o_ff;
               ftag_in = tag_rd_ff;
               st_in = ST_MEVICT;
            end
         end
         ST_MTAG: begin
            ftag_in = tag_rd_ff;
            st_in = ST_MEVICT;
         end
         ST_MEVICT: begin
            if (ftag_ff[PW]) begin
               map_we = 1'b1;
               map_waddr = FW'(ftag_ff[PW-1:0]);
               map_wdata = '0;
               res_in.evicted_page = ftag_ff[PW-1:0];
               res_in.evicted_valid = 1'b1;
            end
            st_in = ST_MFILL;
         end
         ST_MFILL: begin
            map_we = 1'b1;
            map_waddr = FW'(item_ff.req.page);
            map_wdata = {1'b1, f_ff};
            tag_we = 1'b1;
            tag_waddr = f_ff;
            tag_wdata = {1'b1, item_ff.req.page};
            newest_in = f_ff;
            res_in.frame = PW'(f_ff);
            res_in.load_needed = 1'b1;
            last_page_in = item_ff.req.page;
            last_valid_in = 1'b1;
            last_frame_in = f_ff;
            st_in = ST_DONE;
         end
         ST_HA: begin
            // Unlink the frame from between its neighbors.
            next_we = 1'b1;
            next_waddr = prev_rd_ff;
            next_wdata = next_rd_ff;
            prev_we = 1'b1;
            prev_waddr = next_rd_ff;
            prev_wdata = prev_rd_ff;
            old_in = (next_rd_ff == newest_ff) ? prev_rd_ff : o_ff;
            st_in = ST_HB;
         end
         ST_HB: begin
            // Link the frame in after the newest one.
            next_we = 1'b1;
            next_waddr = f_ff;
            next_wdata = newest_ff;
            prev_we = 1'b1;
            prev_waddr = f_ff;
            prev_wdata = old_ff;
            st_in = ST_HC;
         end
         ST_HC: begin
            next_we = 1'b1;
            next_waddr = old_ff;
            next_wdata = f_ff;
            prev_we = 1'b1;
            prev_waddr = newest_ff;
            prev_wdata = f_ff;
            newest_in = f_ff;
            res_in.frame = PW'(f_ff);
            res_in.hit = 1'b1;
            last_page_in = item_ff.req.page;
            last_valid_in = 1'b1;
            last_frame_in = f_ff;
            st_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_SWEEP;
      endcase

      // A configuration write restarts the rebuild sweep.
      if (cfg.rebuild) begin
         st_in = ST_SWEEP;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_SWEEP;
         idx_ff <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      newest_ff <= newest_in;
      last_page_ff <= last_page_in;
      last_frame_ff <= last_frame_in;
      o_ff <= o_in;
      f_ff <= f_in;
      old_ff <= old_in;
      ftag_ff <= ftag_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memory ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      next_rd_ff <= next_mem[next_raddr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      prev_rd_ff <= prev_mem[prev_raddr];
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_rd_ff <= tag_mem[tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign sweeping = (st_ff == ST_SWEEP);

endmodule

@@ bench/lru_page_buffer_manager_test.sv @@
// Self-checking testbench of the LRU page buffer manager.
module lru_page_buffer_manager_test;

   localparam int NPAGES = lpbm_pkg::PAGES_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   lpbm_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   lpbm_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [lpbm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lpbm_pkg::CFG_W-1:0] csr_wdata;

   // Model state of the page buffer.
   logic [lpbm_pkg::CFG_W-1:0] cfg_preload;
   logic [lpbm_pkg::CFG_W-1:0] cfg_buffer;
   logic [7:0] lru_next [NPAGES];
   logic [7:0] lru_prev [NPAGES];
   logic [7:0] owner_page [NPAGES];
   logic owner_ok [NPAGES];
   logic [7:0] page_frame [NPAGES];
   logic page_resident [NPAGES];
   logic [7:0] mru_frame;
   logic [7:0] prev_page;
   logic prev_page_ok;
   logic [7:0] prev_frame;

   lpbm_pkg::rsp_type expected_rsp [$];
   int failures;
   int cycles;
   int rsp_seen;
   int stall_mode;

   lru_page_buffer_manager DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Rebuild the LRU ring in index order and forget all mappings.
   function automatic void ring_rebuild();
      int be;
      int i;
      be = (cfg_buffer > NPAGES) ? NPAGES : int'(cfg_buffer);
      for (i = 0; i < NPAGES; i++) begin
         lru_next[i] = 8'((i + 1) % NPAGES);
         lru_prev[i] = 8'((i + NPAGES - 1) % NPAGES);
         owner_ok[i] = 1'b0;
         owner_page[i] = '0;
         page_resident[i] = 1'b0;
         page_frame[i] = '0;
      end
      mru_frame = '0;
      if (int'(cfg_preload) < be) begin
         for (i = cfg_preload; i < be; i++) begin
            lru_next[i] = 8'((i + 1 == be) ? int'(cfg_preload) : i + 1);
            lru_prev[i] = 8'((i == int'(cfg_preload)) ? be - 1 : i - 1);
         end
         mru_frame = 8'(be - 1);
      end
      prev_page_ok = 1'b0;
      prev_page = '0;
      prev_frame = '0;
   endfunction

   // Work out the result of one lookup and update the model.
   function automatic lpbm_pkg::rsp_type lookup_page(lpbm_pkg::req_type r);
      lpbm_pkg::rsp_type o;
      int be;
      logic [7:0] f;
      logic [7:0] p;
      logic [7:0] n;
      logic [7:0] old;
      o = '0;
      be = (cfg_buffer > NPAGES) ? NPAGES : int'(cfg_buffer);
      if (prev_page_ok && r.page == prev_page) begin
         o.frame = prev_frame;
         o.hit = 1'b1;
      end else if (r.page < cfg_preload) begin
         o.frame = r.page;
         o.hit = 1'b1;
         prev_page = r.page; prev_page_ok = 1'b1; prev_frame = r.page;
      end else if (int'(cfg_preload) >= be) begin
         // No paged frames: empty answer, nothing changes.
      end else if (!page_resident[r.page]) begin
         f = lru_prev[mru_frame];
         if (r.code_page_valid && owner_ok[f] && owner_page[f] == r.code_page)
            f = lru_prev[f];
         if (owner_ok[f]) begin
            page_resident[owner_page[f]] = 1'b0;
            o.evicted_page = owner_page[f];
            o.evicted_valid = 1'b1;
         end
         page_resident[r.page] = 1'b1;
         page_frame[r.page] = f;
         owner_ok[f] = 1'b1;
         owner_page[f] = r.page;
         mru_frame = f;
         o.frame = f;
         o.load_needed = 1'b1;
         prev_page = r.page; prev_page_ok = 1'b1; prev_frame = f;
      end else begin
         f = page_frame[r.page];
         if (f != mru_frame) begin
            p = lru_prev[f];
            n = lru_next[f];
            lru_next[p] = n;
            lru_prev[n] = p;
            old = lru_prev[mru_frame];
            lru_next[f] = mru_frame;
            lru_prev[f] = old;
            lru_prev[mru_frame] = f;
            lru_next[old] = f;
            mru_frame = f;
         end
         o.frame = f;
         o.hit = 1'b1;
         prev_page = r.page; prev_page_ok = 1'b1; prev_frame = f;
      end
      return o;
   endfunction

   // Send one request beat; the sender may pause between random bursts.
   // Valid stays high inside a burst and drops only for a gap.
   int burst_left;
   task automatic send_request(input logic [7:0] pg, input logic [7:0] cp,
                               input logic cv);
      lpbm_pkg::req_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      r.page = pg; r.code_page = cp; r.code_page_valid = cv;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(lookup_page(r));
   endtask

   // Wait for all results, then write one register and rebuild the model.
   task automatic write_register(input logic [lpbm_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [lpbm_pkg::CFG_W-1:0] val);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == lpbm_pkg::REG_PRELOAD_END) cfg_preload = val;
      else cfg_buffer = val;
      ring_rebuild();
   endtask

   // Receiver stall pattern: runs of free flow, light and heavy stalling.
   always @(posedge clock) begin
      if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      lpbm_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: result with none expected: got %p", $time, rsp_data);
            failures++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.frame !== e.frame || rsp_data.hit !== e.hit ||
                rsp_data.load_needed !== e.load_needed ||
                rsp_data.evicted_page !== e.evicted_page ||
                rsp_data.evicted_valid !== e.evicted_valid) begin
               $display("%0t: mismatch: expected %p, got %p", $time, e, rsp_data);
               failures++;
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Extremes of the fields, preloaded, repeat and special cases.
   task automatic test_directed();
      write_register(lpbm_pkg::REG_PRELOAD_END, 9'd4);
      write_register(lpbm_pkg::REG_BUFFER_END, 9'd7);
      send_request(8'd0, 8'd0, 1'b0);
      send_request(8'd0, 8'd0, 1'b0);
      send_request(8'd3, 8'hFF, 1'b1);
      send_request(8'd255, 8'd255, 1'b1);
      send_request(8'd10, 8'd255, 1'b1);
      send_request(8'd11, 8'd255, 1'b1);
      send_request(8'd255, 8'd255, 1'b1);
      // Oldest frame holds the code page, so the second oldest goes.
      send_request(8'd12, 8'd10, 1'b1);
      send_request(8'd13, 8'd10, 1'b1);
      send_request(8'd11, 8'd0, 1'b0);
      send_request(8'd10, 8'd0, 1'b0);
      // One paged frame: reused even though it holds the code page.
      write_register(lpbm_pkg::REG_BUFFER_END, 9'd5);
      send_request(8'd20, 8'd0, 1'b0);
      send_request(8'd21, 8'd20, 1'b1);
      send_request(8'd20, 8'd21, 1'b1);
      // No paged frames, and a buffer end past the map.
      write_register(lpbm_pkg::REG_PRELOAD_END, 9'd256);
      send_request(8'd255, 8'd0, 1'b0);
      send_request(8'd7, 8'd0, 1'b0);
      write_register(lpbm_pkg::REG_PRELOAD_END, 9'd0);
      write_register(lpbm_pkg::REG_BUFFER_END, 9'd0);
      send_request(8'd1, 8'd0, 1'b0);
      write_register(lpbm_pkg::REG_BUFFER_END, 9'd511);
      send_request(8'd128, 8'd0, 1'b0);
      send_request(8'd170, 8'd85, 1'b1);
      send_request(8'd85, 8'd170, 1'b1);
   endtask

   // Random requests over a working set near the ring size.
   task automatic test_random(input int count, input int span);
      int k;
      int base;
      logic [7:0] pg;
      logic [7:0] cp;
      base = $urandom_range(0, 255);
      cp = 8'($urandom_range(0, 255));
      for (k = 0; k < count; k++) begin
         if ($urandom_range(0, 9) == 0) pg = 8'($urandom_range(0, 255));
         else pg = 8'(base + $urandom_range(0, span));
         // Code page usually tracks a recent request.
         if ($urandom_range(0, 3) == 0) cp = pg;
         else if ($urandom_range(0, 9) == 0) cp = 8'($urandom_range(0, 255));
         send_request(pg, cp, 1'($urandom_range(0, 4) != 0));
      end
   endtask

   // Random requests across several settings of the ring bounds.
   task automatic test_configs();
      int s;
      int pe;
      test_random(80, 300);
      for (s = 0; s < 8; s++) begin
         pe = $urandom_range(0, 250);
         write_register(lpbm_pkg::REG_PRELOAD_END, 9'(pe));
         write_register(lpbm_pkg::REG_BUFFER_END, 9'(pe + $urandom_range(1, 12)));
         test_random(60, 20);
      end
      write_register(lpbm_pkg::REG_PRELOAD_END, 9'd0);
      write_register(lpbm_pkg::REG_BUFFER_END, 9'd256);
      test_random(40, 255);
   endtask

   initial begin
      failures = 0;
      cycles = 0;
      burst_left = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_preload = 9'd0;
      cfg_buffer = 9'd256;
      ring_rebuild();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_configs();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
src/lpbm_pkg.sv
src/lpbm_fifo.sv
src/lpbm_front.sv
src/lpbm_back.sv
src/lru_page_buffer_manager.sv
bench/lru_page_buffer_manager_test.sv
